>>> design/quantized_l2_distance_scorer_unit_assert.svh
// Assertion macros for the quantized L2 distance scorer.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef QUANTIZED_L2_DISTANCE_SCORER_UNIT_ASSERT_SVH
`define QUANTIZED_L2_DISTANCE_SCORER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define QLDS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define QLDS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/qlds_pkg.sv
// Shared types and constants of the quantized L2 distance scorer.
// Used by qlds_store, qlds_mac, qlds_score and the top level; no dependencies.
package qlds_pkg;

    // Field widths
    localparam int VALUE_W  = 16;   // Q4.12 centroid / query component
    localparam int CODE_W   = 8;
    localparam int VNORM_W  = 16;   // Q8.8 vector norm
    localparam int SCALED_W = 40;   // 24 fractional bits
    localparam int DIST_W   = 48;   // 24 fractional bits, signed
    localparam int DIM_W    = 11;   // dimension register
    localparam int LBITS_W  = 4;    // level_bits register
    localparam int PROD_W   = 32;   // Q4.12 x Q4.12
    localparam int NORM_W   = 42;   // query norm accumulator, unsigned
    localparam int DOT_W    = 42;   // dot accumulator, signed
    localparam int TERM_W   = 52;   // rounded 2*vec_norm*dot, signed
    localparam int REQ_W    = 2;
    localparam int CFG_A_W  = 1;

    // Request kinds carried in tuser
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CODE  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_DIMENSION  = 1'd0;
    localparam logic [CFG_A_W-1:0] CFG_LEVEL_BITS = 1'd1;

    // Memory access controls
    typedef struct packed {
        logic q_we;     // write query component
        logic c_we;     // write centroid
        logic rd_en;    // read query and centroid for a code
    } store_ctl_t;

    // Multiply-accumulate controls
    typedef struct packed {
        logic mul_en;   // register the product
        logic acc_en;   // fold the product into an accumulator
        logic sel_code; // 1: code item (dot), 0: query item (norm)
        logic clear;    // first element: start from zero
    } mac_ctl_t;

    // Final scoring controls
    typedef struct packed {
        logic scale_en; // partial products of vec_norm * dot
        logic term_en;  // combine and round
    } score_ctl_t;

endpackage

>>> design/qlds_store.sv
// Query and centroid memories, synchronous, registered read.
// Depends on qlds_pkg for the control struct and the value width.
module qlds_store #(
    parameter int DIM_MAX    = 1024,
    parameter int LEVELS_MAX = 256
) (
    input  logic                              aclk,
    input  qlds_pkg::store_ctl_t              ctl,
    input  logic [((DIM_MAX > 1) ? $clog2(DIM_MAX) : 1)-1:0] q_addr,
    input  logic [$clog2(LEVELS_MAX)-1:0]     c_addr,
    input  logic [qlds_pkg::VALUE_W-1:0]      wdata,
    output logic [qlds_pkg::VALUE_W-1:0]      q_rdata,
    output logic [qlds_pkg::VALUE_W-1:0]      c_rdata
);

    logic [qlds_pkg::VALUE_W-1:0] q_mem [DIM_MAX];
    logic [qlds_pkg::VALUE_W-1:0] c_mem [LEVELS_MAX];

    // Query store port
    always_ff @(posedge aclk) begin
        if (ctl.q_we) begin
            q_mem[q_addr] <= wdata;
        end
        if (ctl.rd_en) begin
            q_rdata <= q_mem[q_addr];
        end
    end

    // Codebook port
    always_ff @(posedge aclk) begin
        if (ctl.c_we) begin
            c_mem[c_addr] <= wdata;
        end
        if (ctl.rd_en) begin
            c_rdata <= c_mem[c_addr];
        end
    end

endmodule

>>> design/qlds_mac.sv
// Shared multiplier and the two saturating accumulators (query norm, dot).
// Depends on qlds_pkg for the control struct and widths.
module qlds_mac (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  qlds_pkg::mac_ctl_t                 ctl,
    input  logic signed [qlds_pkg::VALUE_W-1:0] value,
    input  logic signed [qlds_pkg::VALUE_W-1:0] q_rdata,
    input  logic signed [qlds_pkg::VALUE_W-1:0] c_rdata,
    output logic [qlds_pkg::NORM_W-1:0]        norm,
    output logic signed [qlds_pkg::DOT_W-1:0]  dot
);

    localparam logic [qlds_pkg::NORM_W-1:0] NORM_MAX = '1;
    localparam logic signed [qlds_pkg::DOT_W:0] DOT_MAX =
        (43'sd1 <<< (qlds_pkg::DOT_W - 1)) - 43'sd1;
    localparam logic signed [qlds_pkg::DOT_W:0] DOT_MIN =
        -(43'sd1 <<< (qlds_pkg::DOT_W - 1));

    logic signed [qlds_pkg::VALUE_W-1:0] op_a;
    logic signed [qlds_pkg::VALUE_W-1:0] op_b;
    logic signed [qlds_pkg::PROD_W-1:0]  prod_reg;
    logic signed [qlds_pkg::PROD_W-1:0]  prod_next;
    logic [qlds_pkg::NORM_W-1:0]         norm_reg;
    logic [qlds_pkg::NORM_W-1:0]         norm_next;
    logic signed [qlds_pkg::DOT_W-1:0]   dot_reg;
    logic signed [qlds_pkg::DOT_W-1:0]   dot_next;
    logic [qlds_pkg::NORM_W-1:0]         norm_base;
    logic signed [qlds_pkg::DOT_W-1:0]   dot_base;
    logic [qlds_pkg::NORM_W:0]           norm_sum;
    logic signed [qlds_pkg::DOT_W:0]     dot_sum;

    // Operand select: square of the query component, or query times centroid
    always_comb begin
        op_a      = ctl.sel_code ? q_rdata : value;
        op_b      = ctl.sel_code ? c_rdata : value;
        prod_next = op_a * op_b;
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= prod_next;
        end
    end

    // Saturating accumulate; the first element of a run starts from zero
    always_comb begin
        norm_base = ctl.clear ? '0 : norm_reg;
        dot_base  = ctl.clear ? '0 : dot_reg;
        // a square is never negative
        norm_sum  = {1'b0, norm_base} + {11'd0, prod_reg};
        dot_sum   = 43'(dot_base) + 43'(prod_reg);
        norm_next = norm_reg;
        dot_next  = dot_reg;
        if (ctl.acc_en && !ctl.sel_code) begin
            norm_next = norm_sum[qlds_pkg::NORM_W] ? NORM_MAX
                                                   : norm_sum[qlds_pkg::NORM_W-1:0];
        end
        if (ctl.acc_en && ctl.sel_code) begin
            priority if (dot_sum > DOT_MAX) begin
                dot_next = DOT_MAX[qlds_pkg::DOT_W-1:0];
            end else if (dot_sum < DOT_MIN) begin
                dot_next = DOT_MIN[qlds_pkg::DOT_W-1:0];
            end else begin
                dot_next = dot_sum[qlds_pkg::DOT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_reg <= '0;
            dot_reg  <= '0;
        end else begin
            norm_reg <= norm_next;
            dot_reg  <= dot_next;
        end
    end

    assign norm = norm_reg;
    assign dot  = dot_reg;

endmodule

>>> design/qlds_score.sv
// Final score: query_norm + scaled_norm - round(2 * vec_norm * dot), saturated.
// Two registered stages; depends on qlds_pkg for widths and the control struct.
module qlds_score (
    input  logic                               aclk,
    input  qlds_pkg::score_ctl_t               ctl,
    input  logic signed [qlds_pkg::DOT_W-1:0]  dot,
    input  logic [qlds_pkg::VNORM_W-1:0]       vec_norm,
    input  logic [qlds_pkg::NORM_W-1:0]        norm,
    input  logic [qlds_pkg::SCALED_W-1:0]      scaled,
    output logic [qlds_pkg::DIST_W-1:0]        distance
);

    localparam int HALF_W = qlds_pkg::DOT_W / 2;    // dot split point
    localparam int FULL_W = 60;
    localparam int SUM_W  = 54;
    localparam logic signed [SUM_W-1:0] OUT_MAX = (54'sd1 <<< (qlds_pkg::DIST_W - 1)) - 54'sd1;
    localparam logic signed [SUM_W-1:0] OUT_MIN = -(54'sd1 <<< (qlds_pkg::DIST_W - 1));

    logic [HALF_W+qlds_pkg::VNORM_W-1:0]          p_lo_reg;
    logic signed [HALF_W+qlds_pkg::VNORM_W:0]     p_hi_reg;
    logic signed [HALF_W-1:0]                     dot_hi;
    logic signed [qlds_pkg::VNORM_W:0]            vnorm_s;
    logic signed [FULL_W-1:0]                     full;
    logic signed [FULL_W-1:0]                     twice_rnd;
    logic signed [qlds_pkg::TERM_W-1:0]           term_reg;
    logic signed [SUM_W-1:0]                      dist_wide;

    // Stage 1: dot split into a signed high and an unsigned low half
    always_comb begin
        dot_hi  = dot[qlds_pkg::DOT_W-1:HALF_W];
        vnorm_s = {1'b0, vec_norm};
    end

    always_ff @(posedge aclk) begin
        if (ctl.scale_en) begin
            p_lo_reg <= dot[HALF_W-1:0] * vec_norm;
            p_hi_reg <= dot_hi * vnorm_s;
        end
    end

    // Stage 2: recombine, double, round half up to 24 fractional bits
    always_comb begin
        full      = (FULL_W'(p_hi_reg) <<< HALF_W) + $signed(FULL_W'(p_lo_reg));
        twice_rnd = (full <<< 1) + 60'sd128;
    end

    always_ff @(posedge aclk) begin
        if (ctl.term_en) begin
            term_reg <= twice_rnd[FULL_W-1:8];
        end
    end

    // Exact sum, then saturate to the output width
    always_comb begin
        dist_wide = $signed({12'd0, norm}) + $signed({14'd0, scaled}) - SUM_W'(term_reg);
        priority if (dist_wide > OUT_MAX) begin
            distance = OUT_MAX[qlds_pkg::DIST_W-1:0];
        end else if (dist_wide < OUT_MIN) begin
            distance = OUT_MIN[qlds_pkg::DIST_W-1:0];
        end else begin
            distance = dist_wide[qlds_pkg::DIST_W-1:0];
        end
    end

endmodule

>>> design/quantized_l2_distance_scorer_unit.sv
// Top level of the quantized L2 distance scorer: sequencer, position, config, output.
// Depends on qlds_pkg, qlds_store, qlds_mac, qlds_score and the assertion header.
//
//  channel | direction | payload
//  --------+-----------+-------------------------------------------------------
//  s_      | in        | tdata: value, code, vec_norm, vec_scaled_norm_sq;
//          |           | tuser: req_type, start_req
//  m_      | out       | tdata: distance
//  cfg_    | in        | write only: 0 dimension, 1 level_bits
//
// One transaction at a time. A centroid load or unused kind passes accept and memory
// access; a query component or a non-final code passes accept, memory access, multiply
// and accumulate; the last code of a vector adds scale, term and output plus any wait
// for m_tready. The registered memory read and the single shared multiplier set these steps.
// The output register holds one result; the next transaction is accepted while it waits.
// Reset (aresetn low, synchronous) clears accumulators, position and config to defaults;
// memory contents are undefined until written.
module quantized_l2_distance_scorer_unit #(
    parameter int DIM_MAX    = 1024,
    parameter int LEVELS_MAX = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,    // [15:0] value, [23:16] code, [39:24] vec_norm,
                                    // [79:40] vec_scaled_norm_sq
    input  logic [2:0]  s_tuser,    // [1:0] req_type, [2] start_req
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [47:0] distance
    // configuration
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_addr,
    input  logic [10:0] cfg_wdata
);

    localparam int Q_ADDR_W = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int C_ADDR_W = $clog2(LEVELS_MAX);
    localparam int CNT_W    = ($clog2(DIM_MAX + 1) > qlds_pkg::DIM_W)
                              ? $clog2(DIM_MAX + 1) : qlds_pkg::DIM_W;
    localparam int CMP_W    = CNT_W + 1;
    // ceil(2^16 / LEVELS_MAX): exact quotient for every 8-bit code
    localparam logic [15:0] LEVELS_RECIP = 16'((65536 + LEVELS_MAX - 1) / LEVELS_MAX);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MEM   = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_ACC   = 7'b0001000,
        ST_SCALE = 7'b0010000,
        ST_TERM  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // item registers
    logic [qlds_pkg::REQ_W-1:0]    req_reg;
    logic                          start_reg;
    logic [qlds_pkg::VALUE_W-1:0]  value_reg;
    logic [qlds_pkg::CODE_W-1:0]   code_reg;
    logic [qlds_pkg::VNORM_W-1:0]  vnorm_reg;
    logic [qlds_pkg::SCALED_W-1:0] scaled_reg;
    logic                          last_reg;
    logic                          last_next;

    logic [Q_ADDR_W-1:0]           pos_reg, pos_next, pos_eff;
    logic [qlds_pkg::DIM_W-1:0]    dimension_reg, dimension_next;
    logic [qlds_pkg::LBITS_W-1:0]  level_bits_reg, level_bits_next;
    logic [qlds_pkg::LBITS_W-1:0]  eff_bits;
    logic [CMP_W-1:0]              eff_dim;
    logic [qlds_pkg::CODE_W-1:0]   code_mask;
    logic [qlds_pkg::CODE_W-1:0]   slot_src;
    logic [C_ADDR_W-1:0]           c_addr;
    logic                          is_elem;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [qlds_pkg::DIST_W-1:0]   m_tdata_reg;
    logic                          out_load;

    qlds_pkg::store_ctl_t          store_ctl;
    qlds_pkg::mac_ctl_t            mac_ctl;
    qlds_pkg::score_ctl_t          score_ctl;
    logic [qlds_pkg::VALUE_W-1:0]  q_rdata, c_rdata;
    logic [qlds_pkg::NORM_W-1:0]   norm_acc;
    logic signed [qlds_pkg::DOT_W-1:0] dot_acc;
    logic [qlds_pkg::DIST_W-1:0]   distance;

    // Codebook slot: remainder modulo LEVELS_MAX through a reciprocal multiply
    function automatic logic [C_ADDR_W-1:0] levels_mod(input logic [qlds_pkg::CODE_W-1:0] x);
        logic [23:0] prod;
        logic [7:0]  quo;
        logic [16:0] rem;
        prod = 24'(x) * 24'(LEVELS_RECIP);
        quo  = prod[23:16];
        rem  = 17'(x) - 17'(quo) * 17'(LEVELS_MAX);
        return rem[C_ADDR_W-1:0];
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Capture the accepted transaction
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            value_reg  <= s_tdata[15:0];
            code_reg   <= s_tdata[23:16];
            vnorm_reg  <= s_tdata[39:24];
            scaled_reg <= s_tdata[79:40];
            req_reg    <= s_tuser[1:0];
            start_reg  <= s_tuser[2];
        end
        last_reg <= last_next;
        if (out_load) begin
            m_tdata_reg <= distance;
        end
    end

    // Effective config values, clamped
    always_comb begin
        eff_bits = (level_bits_reg == '0) ? 4'd1
                 : ((level_bits_reg > 4'd8) ? 4'd8 : level_bits_reg);
        code_mask = 8'hFF >> (4'd8 - eff_bits);
        if (dimension_reg == '0) begin
            eff_dim = CMP_W'(1);
        end else if (CMP_W'(dimension_reg) > CMP_W'(DIM_MAX)) begin
            eff_dim = CMP_W'(DIM_MAX);
        end else begin
            eff_dim = CMP_W'(dimension_reg);
        end
    end

    // Addresses and position
    always_comb begin
        is_elem   = (req_reg == qlds_pkg::REQ_QUERY) || (req_reg == qlds_pkg::REQ_CODE);
        pos_eff   = start_reg ? '0 : pos_reg;
        slot_src  = (req_reg == qlds_pkg::REQ_LOAD) ? code_reg : (code_reg & code_mask);
        c_addr    = levels_mod(slot_src);
        last_next = last_reg;
        pos_next  = pos_reg;
        if (state_reg == ST_MEM && is_elem) begin
            last_next = (CMP_W'(pos_eff) + CMP_W'(1)) >= eff_dim;
            pos_next  = last_next ? '0 : (pos_eff + Q_ADDR_W'(1));
        end
    end

    // Configuration writes
    always_comb begin
        dimension_next  = dimension_reg;
        level_bits_next = level_bits_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                qlds_pkg::CFG_DIMENSION:  dimension_next  = cfg_wdata;
                qlds_pkg::CFG_LEVEL_BITS: level_bits_next = cfg_wdata[3:0];
            endcase
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        store_ctl  = '0;
        mac_ctl    = '0;
        score_ctl  = '0;
        out_load   = 1'b0;
        mac_ctl.sel_code = (req_reg == qlds_pkg::REQ_CODE);
        mac_ctl.clear    = start_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MEM;
                end
            end
            ST_MEM: begin
                store_ctl.c_we  = (req_reg == qlds_pkg::REQ_LOAD);
                store_ctl.q_we  = (req_reg == qlds_pkg::REQ_QUERY);
                store_ctl.rd_en = (req_reg == qlds_pkg::REQ_CODE);
                state_next = is_elem ? ST_MUL : ST_IDLE;
            end
            ST_MUL: begin
                mac_ctl.mul_en = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                mac_ctl.acc_en = 1'b1;
                state_next = (mac_ctl.sel_code && last_reg) ? ST_SCALE : ST_IDLE;
            end
            ST_SCALE: begin
                score_ctl.scale_en = 1'b1;
                state_next = ST_TERM;
            end
            ST_TERM: begin
                score_ctl.term_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            dimension_reg  <= 11'd128;
            level_bits_reg <= 4'd4;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            dimension_reg  <= dimension_next;
            level_bits_reg <= level_bits_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    qlds_store #(
        .DIM_MAX    (DIM_MAX),
        .LEVELS_MAX (LEVELS_MAX)
    ) u_store (
        .aclk    (aclk),
        .ctl     (store_ctl),
        .q_addr  (pos_eff),
        .c_addr  (c_addr),
        .wdata   (value_reg),
        .q_rdata (q_rdata),
        .c_rdata (c_rdata)
    );

    qlds_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .value   (value_reg),
        .q_rdata (q_rdata),
        .c_rdata (c_rdata),
        .norm    (norm_acc),
        .dot     (dot_acc)
    );

    qlds_score u_score (
        .aclk     (aclk),
        .ctl      (score_ctl),
        .dot      (dot_acc),
        .vec_norm (vnorm_reg),
        .norm     (norm_acc),
        .scaled   (scaled_reg),
        .distance (distance)
    );

`include "quantized_l2_distance_scorer_unit_assert.svh"

    // one transaction in flight
    `QLDS_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "accepted while busy")
    // results come only out of the output state
    `QLDS_ASSERT_IMP(a_out_src, aclk, aresetn, $rose(m_tvalid), $past(state_reg == ST_OUT), "stray result")
    // only the last code of a vector produces a result
    `QLDS_ASSERT_IMP(a_out_code, aclk, aresetn, out_load, (req_reg == qlds_pkg::REQ_CODE) && last_reg, "result from non-final item")
    // continuing query never lowers the norm
    `QLDS_ASSERT_NXT(a_norm_mono, aclk, aresetn, (state_reg == ST_ACC) && (req_reg == qlds_pkg::REQ_QUERY) && !start_reg, norm_acc >= $past(norm_acc), "query norm decreased")
    // memories are touched only in the access state
    `QLDS_ASSERT_IMP(a_mem_slot, aclk, aresetn, store_ctl.q_we || store_ctl.c_we || store_ctl.rd_en, state_reg == ST_MEM, "memory access out of sequence")

endmodule

>>> test/quantized_l2_distance_scorer_unit_tb.sv
// Testbench for quantized_l2_distance_scorer_unit: directed and random stimulus,
// a bit-exact distance predictor and an in-order result check.
// Depends on qlds_pkg and the RTL of the block only.
module tb;

    localparam int DIM_MAX    = 1024;
    localparam int LEVELS_MAX = 256;
    localparam int LIMIT      = 1_000_000;
    localparam int SETTLE     = 12;     // idle margin after the last result
    localparam int SAT_DIM    = 260;    // run long enough that its extremes saturate the distance

    // Request kind that the block ignores
    localparam logic [qlds_pkg::REQ_W-1:0] REQ_RESERVED = 2'd3;

    localparam longint NORM_CAP = (longint'(1) << 42) - 1;
    localparam longint DOT_HI   = (longint'(1) << 41) - 1;
    localparam longint DOT_LO   = -(longint'(1) << 41);
    localparam longint DIST_HI  = (longint'(1) << 47) - 1;
    localparam longint DIST_LO  = -(longint'(1) << 47);

    // Random phases: dimension, level_bits and item count of each
    localparam int PHASE_DIM   [9] = '{1, 3, 0, 5, 8, 16, 40, 128, 4};
    localparam int PHASE_LBITS [9] = '{1, 8, 0, 3, 4, 6, 15, 7, 2};
    localparam int PHASE_ITEMS [9] = '{100, 150, 60, 250, 150, 150, 80, 100, 120};

    // Predicts the distance of every scored vector and checks the results in order
    class distance_checker;
        logic [10:0]        dim_reg;
        logic [3:0]         lbits_reg;
        logic signed [15:0] query_mem [DIM_MAX];
        bit                 query_written [DIM_MAX];
        logic signed [15:0] centroid_mem [LEVELS_MAX];
        bit                 centroid_written [LEVELS_MAX];
        longint             norm_acc;
        longint             dot_acc;
        int unsigned        pos;
        logic [47:0]        pending_distances [$];
        int                 errors;

        function new();
            dim_reg   = 11'd128;
            lbits_reg = 4'd4;
            norm_acc  = 0;
            dot_acc   = 0;
            pos       = 0;
            errors    = 0;
        endfunction

        function int unsigned eff_dim();
            if (dim_reg == 0) return 1;
            if (dim_reg > DIM_MAX) return DIM_MAX;
            return dim_reg;
        endfunction

        function int unsigned eff_bits();
            if (lbits_reg == 0) return 1;
            if (lbits_reg > 8) return 8;
            return lbits_reg;
        endfunction

        function void write_reg(logic [qlds_pkg::CFG_A_W-1:0] addr, logic [10:0] data);
            if (addr == qlds_pkg::CFG_DIMENSION) begin
                dim_reg = data;
            end else begin
                lbits_reg = data[3:0];
            end
        endfunction

        // Step the shared position; 1 when this element closed the run
        function bit advance();
            if (pos + 1 >= eff_dim()) begin
                pos = 0;
                return 1'b1;
            end
            pos++;
            return 1'b0;
        endfunction

        function int pending();
            return pending_distances.size();
        endfunction

        // Fold one accepted input transaction into the predicted state
        function void take_item(logic [1:0] req, bit start, logic signed [15:0] val,
                                logic [7:0] code, logic [15:0] vnorm, logic [39:0] scaled);
            logic [7:0] mask;
            logic [7:0] slot;
            longint     prod;
            longint     term;
            longint     dist_val;
            case (req)
                qlds_pkg::REQ_LOAD: begin
                    centroid_mem[code]     = val;
                    centroid_written[code] = 1'b1;
                end
                qlds_pkg::REQ_QUERY: begin
                    if (start) begin
                        pos      = 0;
                        norm_acc = 0;
                    end
                    query_mem[pos % DIM_MAX]     = val;
                    query_written[pos % DIM_MAX] = 1'b1;
                    norm_acc = norm_acc + longint'(val) * longint'(val);
                    if (norm_acc > NORM_CAP) norm_acc = NORM_CAP;
                    void'(advance());
                end
                qlds_pkg::REQ_CODE: begin
                    mask = 8'((1 << eff_bits()) - 1);
                    slot = code & mask;
                    if (start) begin
                        pos     = 0;
                        dot_acc = 0;
                    end
                    prod    = longint'(query_mem[pos % DIM_MAX]) * longint'(centroid_mem[slot]);
                    dot_acc = dot_acc + prod;
                    if (dot_acc > DOT_HI) dot_acc = DOT_HI;
                    if (dot_acc < DOT_LO) dot_acc = DOT_LO;
                    if (advance()) begin
                        // round half up from 32 to 24 fractional bits
                        term     = (2 * longint'(vnorm) * dot_acc + 128) >>> 8;
                        dist_val = norm_acc + longint'(scaled) - term;
                        if (dist_val > DIST_HI) dist_val = DIST_HI;
                        if (dist_val < DIST_LO) dist_val = DIST_LO;
                        pending_distances.push_back(dist_val[47:0]);
                    end
                end
                default: ;
            endcase
        endfunction

        // Compare one result transaction against the oldest prediction
        function void check_distance(logic [47:0] got);
            logic [47:0] want;
            if (pending_distances.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected distance %0d (0x%h)", $signed(got), got);
                return;
            end
            want = pending_distances.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("distance: expected %0d (0x%h), actual %0d (0x%h)",
                             $signed(want), want, $signed(got), got);
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;    // [15:0] value, [23:16] code, [39:24] vec_norm,
                                    // [79:40] vec_scaled_norm_sq
    logic [2:0]  s_tuser   = '0;    // [1:0] req_type, [2] start_req
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;           // [47:0] distance
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_addr  = '0;
    logic [10:0] cfg_wdata = '0;

    distance_checker book;
    bit              calm = 1'b0;   // no idling on either side while set
    int              items_sent = 0;
    int              cycles = 0;

    quantized_l2_distance_scorer_unit #(
        .DIM_MAX    (DIM_MAX),
        .LEVELS_MAX (LEVELS_MAX)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result side: check accepted transactions, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            book.check_distance(m_tdata);
        m_tready <= calm || ($urandom_range(99) >= 11);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("quantized_l2_distance_scorer_unit: mismatch");
            $finish;
        end
    end

    function automatic logic [15:0] rand_value();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_vnorm();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [39:0] rand_scaled();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return 40'({$urandom, $urandom});
        endcase
    endfunction

    // Present one input transaction and wait for it to be taken
    task automatic send_item(input logic [1:0] req, input bit start, input logic [15:0] val,
                             input logic [7:0] code, input logic [15:0] vnorm,
                             input logic [39:0] scaled);
        while (!calm && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {scaled, vnorm, code, val};
        s_tuser  <= {start, req};
        do @(posedge aclk); while (!s_tready);
        book.take_item(req, start, val, code, vnorm, scaled);
        if (req != REQ_RESERVED) items_sent++;
    endtask

    // Code element that only reads codebook and query entries already written
    task automatic send_code(input bit start, input logic [7:0] code, input logic [15:0] vnorm,
                             input logic [39:0] scaled);
        logic [7:0]  mask;
        logic [7:0]  slot;
        logic [7:0]  pick;
        int unsigned p;
        mask = 8'((1 << book.eff_bits()) - 1);
        slot = code & mask;
        if (!book.centroid_written[slot]) begin
            slot = '0;
            repeat (8) begin
                pick = 8'($urandom_range(mask));
                if (book.centroid_written[pick]) slot = pick;
            end
            code = (code & ~mask) | slot;
        end
        p = start ? 0 : book.pos;
        if (!book.query_written[p % DIM_MAX]) start = 1'b1;
        send_item(qlds_pkg::REQ_CODE, start, rand_value(), code, vnorm, scaled);
    endtask

    task automatic send_query_run(input bit with_start, input bit fixed_on,
                                  input logic [15:0] fixed_val);
        for (int i = 0; i < book.eff_dim(); i++)
            send_item(qlds_pkg::REQ_QUERY, with_start && i == 0,
                      fixed_on ? fixed_val : rand_value(),
                      8'($urandom), rand_vnorm(), rand_scaled());
    endtask

    // code_sel < 0: random codes and norms; otherwise that code with the largest norms
    task automatic send_vector_run(input bit with_start, input int code_sel);
        for (int i = 0; i < book.eff_dim(); i++) begin
            if (code_sel < 0)
                send_code(with_start && i == 0, 8'($urandom), rand_vnorm(), rand_scaled());
            else
                send_code(with_start && i == 0, 8'(code_sel), 16'hFFFF, '1);
        end
    endtask

    // Hold off the sender until every predicted distance has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_config(input int dim_val, input int lbits_val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= qlds_pkg::CFG_DIMENSION;
        cfg_wdata <= 11'(dim_val);
        @(posedge aclk);
        book.write_reg(qlds_pkg::CFG_DIMENSION, 11'(dim_val));
        cfg_addr  <= qlds_pkg::CFG_LEVEL_BITS;
        cfg_wdata <= 11'(lbits_val);
        @(posedge aclk);
        book.write_reg(qlds_pkg::CFG_LEVEL_BITS, 11'(lbits_val));
        cfg_wr_en <= 1'b0;
    endtask

    // A full query when some position of the current dimension was never written
    task automatic ensure_query();
        bit missing;
        missing = 1'b0;
        for (int i = 0; i < book.eff_dim(); i++)
            if (!book.query_written[i]) missing = 1'b1;
        if (missing) send_query_run(1'b1, 1'b0, '0);
    endtask

    // Mostly well-formed queries and vectors, some loads, some stray elements
    task automatic run_random(input int goal, input int pause_rel);
        int target;
        int pause_at;
        int r;
        logic [1:0] req;
        target   = items_sent + goal;
        pause_at = pause_rel > 0 ? items_sent + pause_rel : 0;
        while (items_sent < target) begin
            if (pause_at > 0 && items_sent >= pause_at) begin
                drain();
                pause_at = 0;
            end
            r = $urandom_range(99);
            if (r < 10) begin
                send_item(qlds_pkg::REQ_LOAD, 1'($urandom), rand_value(), 8'($urandom),
                          rand_vnorm(), rand_scaled());
            end else if (r < 25) begin
                send_query_run($urandom_range(9) != 0, 1'b0, '0);
            end else if (r < 85) begin
                send_vector_run($urandom_range(9) != 0, -1);
            end else begin
                req = 2'($urandom_range(3));
                if (req == qlds_pkg::REQ_CODE)
                    send_code(1'($urandom), 8'($urandom), rand_vnorm(), rand_scaled());
                else
                    send_item(req, 1'($urandom), rand_value(), 8'($urandom), rand_vnorm(),
                              rand_scaled());
            end
        end
    endtask

    // Extreme query and codes with the largest norms push the distance past both limits
    task automatic saturate_output();
        set_config(SAT_DIM, 8);
        send_item(qlds_pkg::REQ_LOAD, 1'b0, 16'h8000, 8'd0, rand_vnorm(), rand_scaled());
        send_item(qlds_pkg::REQ_LOAD, 1'b0, 16'h7FFF, 8'd1, rand_vnorm(), rand_scaled());
        send_query_run(1'b1, 1'b1, 16'h8000);
        // positive dot: low limit
        send_vector_run(1'b1, 0);
        // negative dot: high limit
        send_vector_run(1'b1, 1);
    endtask

    initial begin
        book = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: codebook extremes, one query, ignored kind, vectors at the extremes
        set_config(4, 2);
        send_item(qlds_pkg::REQ_LOAD, 1'b1, 16'h8000, 8'd0, 16'hFFFF, '1);
        send_item(qlds_pkg::REQ_LOAD, 1'b0, 16'h7FFF, 8'd1, 16'h0000, '0);
        send_item(qlds_pkg::REQ_LOAD, 1'b0, 16'h0001, 8'd2, rand_vnorm(), rand_scaled());
        send_item(qlds_pkg::REQ_LOAD, 1'b0, 16'h0000, 8'd3, rand_vnorm(), rand_scaled());
        send_item(qlds_pkg::REQ_LOAD, 1'b0, 16'hFFFF, 8'd128, rand_vnorm(), rand_scaled());
        send_item(qlds_pkg::REQ_LOAD, 1'b1, 16'h7FFF, 8'd255, rand_vnorm(), rand_scaled());
        send_item(qlds_pkg::REQ_QUERY, 1'b1, 16'h8000, 8'hFF, rand_vnorm(), rand_scaled());
        send_item(qlds_pkg::REQ_QUERY, 1'b0, 16'h7FFF, 8'h00, rand_vnorm(), rand_scaled());
        send_item(qlds_pkg::REQ_QUERY, 1'b0, 16'h0000, 8'hAA, rand_vnorm(), rand_scaled());
        send_item(qlds_pkg::REQ_QUERY, 1'b0, 16'hFFFF, 8'h55, rand_vnorm(), rand_scaled());
        send_item(REQ_RESERVED, 1'b1, rand_value(), 8'($urandom), rand_vnorm(), rand_scaled());
        // high code bits above level_bits are dropped
        send_code(1'b1, 8'hFC, 16'hFFFF, '0);
        send_code(1'b0, 8'h01, 16'hFFFF, '0);
        send_code(1'b0, 8'hFE, 16'hFFFF, '0);
        send_code(1'b0, 8'h03, 16'hFFFF, '1);
        for (int i = 0; i < 4; i++)
            send_code(i == 0, 8'h00, 16'h0000, '0);
        // position left beyond a lowered dimension closes the vector at once
        for (int i = 0; i < 3; i++)
            send_item(qlds_pkg::REQ_QUERY, i == 0, rand_value(), 8'($urandom), rand_vnorm(),
                      rand_scaled());
        set_config(2, 2);
        send_code(1'b0, 8'h02, rand_vnorm(), rand_scaled());

        // Random phases over several register settings
        for (int i = 0; i < 9; i++) begin
            if (i == 6) saturate_output();
            set_config(PHASE_DIM[i], PHASE_LBITS[i]);
            calm = (i == 3);
            ensure_query();
            run_random(PHASE_ITEMS[i], i == 8 ? PHASE_ITEMS[i] / 2 : 0);
        end
        calm = 1'b0;

        drain();
        repeat (20) @(posedge aclk);
        if (book.errors == 0) begin
            $display("quantized_l2_distance_scorer_unit: match");
        end else begin
            $display("quantized_l2_distance_scorer_unit: mismatch");
        end
        $finish;
    end
endmodule
